/* rtl/dni_pkg.sv */
`default_nettype none

package dni_pkg;

    localparam int DIGEST_BITS    = 128;
    localparam int BITS_PER_STAGE = 8;
    localparam int STAGES         = DIGEST_BITS / BITS_PER_STAGE;
    localparam int NODE_WIDTH     = 16;

    localparam logic [NODE_WIDTH-1:0] NODE_COUNT_RESET = 16'd10;

endpackage

`default_nettype wire

/* rtl/digest_to_node_index.sv */
// Results pass from the stage registers into the output register, or via the skid entry.
// Throughput: one transaction per cycle while in_stall is low; 16 stages reduce 8 digest bits each.
// The output holds one result and a single skid entry; input stall follows the skid entry.
// Reset (rst_n, async, active low): pipeline, output and skid entry empty,
// node count set to 10.
`default_nettype none

module digest_to_node_index #(
    parameter int MOD_WIDTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [dni_pkg::NODE_WIDTH-1:0]     cfg_wr_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [dni_pkg::DIGEST_BITS/2-1:0]  digest_high,
    input  wire logic [dni_pkg::DIGEST_BITS/2-1:0]  digest_low,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [dni_pkg::NODE_WIDTH-1:0]          node_index
);

    localparam int DIGEST_BITS    = dni_pkg::DIGEST_BITS;
    localparam int BITS_PER_STAGE = dni_pkg::BITS_PER_STAGE;
    localparam int STAGES         = dni_pkg::STAGES;
    localparam int NODE_WIDTH     = dni_pkg::NODE_WIDTH;

    // Restoring remainder steps, one digest bit each, MSB first.
    function automatic logic [MOD_WIDTH-1:0] fold_bits(
        input logic [MOD_WIDTH-1:0]      rem_in,
        input logic [BITS_PER_STAGE-1:0] bits,
        input logic [MOD_WIDTH-1:0]      n
    );
        logic [MOD_WIDTH:0]   acc;
        logic [MOD_WIDTH-1:0] r;
        r = rem_in;
        for (int i = BITS_PER_STAGE - 1; i >= 0; i--)
        begin
            acc = {r, bits[i]};
            if (acc >= {1'b0, n})
            begin
                acc = acc - {1'b0, n};
            end
            r = acc[MOD_WIDTH-1:0];
        end
        return r;
    endfunction

    logic [MOD_WIDTH-1:0]            node_count_reg;
    logic [MOD_WIDTH+NODE_WIDTH-1:0] cfg_ext;
    logic [MOD_WIDTH+NODE_WIDTH-1:0] reset_ext;

    logic                    pipe_en;
    logic                    in_accept;
    logic [STAGES-1:0]       stage_valid_reg;
    logic [MOD_WIDTH-1:0]    rem_reg    [STAGES];
    logic [DIGEST_BITS-1:0]  digest_reg [STAGES];
    logic [MOD_WIDTH-1:0]    rem_in     [STAGES];
    logic [DIGEST_BITS-1:0]  digest_in  [STAGES];

    logic                    last_valid;
    logic [MOD_WIDTH-1:0]    last_rem;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [MOD_WIDTH-1:0]    out_rem_reg;
    logic [MOD_WIDTH-1:0]    out_rem_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic [MOD_WIDTH-1:0]    skid_rem_reg;
    logic [MOD_WIDTH-1:0]    skid_rem_next;
    logic [MOD_WIDTH+NODE_WIDTH-1:0] out_ext;

    assign cfg_ext   = {MOD_WIDTH'(0), cfg_wr_data};
    assign reset_ext = {MOD_WIDTH'(0), dni_pkg::NODE_COUNT_RESET};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= reset_ext[MOD_WIDTH-1:0];
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_ext[MOD_WIDTH-1:0];
        end
    end

    assign pipe_en   = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign rem_in[k]    = '0;
            assign digest_in[k] = {digest_high, digest_low};
        end
        else
        begin : g_next
            assign rem_in[k]    = rem_reg[k-1];
            assign digest_in[k] = digest_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
            else if (pipe_en)
            begin
                stage_valid_reg[k] <= (k == 0) ? in_accept : stage_valid_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                digest_reg[k] <= digest_in[k];
                rem_reg[k]    <= fold_bits(rem_in[k],
                    digest_in[k][DIGEST_BITS-1-k*BITS_PER_STAGE -: BITS_PER_STAGE],
                    node_count_reg);
            end
        end
    end

    // Zero node count answers zero.
    assign last_valid = stage_valid_reg[STAGES-1];
    assign last_rem   = (node_count_reg == '0) ? '0 : rem_reg[STAGES-1];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_rem_next    = out_rem_reg;
        skid_valid_next = skid_valid_reg;
        skid_rem_next   = skid_rem_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rem_next    = skid_rem_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = last_valid;
                out_rem_next   = last_rem;
            end
        end
        else if (pipe_en && last_valid)
        begin
            skid_valid_next = 1'b1;
            skid_rem_next   = last_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rem_reg  <= out_rem_next;
        skid_rem_reg <= skid_rem_next;
    end

    assign out_ext    = {NODE_WIDTH'(0), out_rem_reg};
    assign out_valid  = out_valid_reg;
    assign node_index = out_ext[NODE_WIDTH-1:0];

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_rem_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && node_count_reg != '0) |-> (out_rem_reg < node_count_reg))
        else $error("remainder not below node count");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(stage_valid_reg))
        else $error("pipeline moved while frozen");

    a_skid_release: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not released into output register");
`endif

endmodule

`default_nettype wire

/* bench/tb_digest_to_node_index.sv */
`timescale 1ns / 100ps

module tb_digest_to_node_index;

    localparam int NODE_WIDTH   = dni_pkg::NODE_WIDTH;
    localparam int MOD_WIDTH    = 16;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PHASE_ITEMS  = 140;
    localparam int BURST_ITEMS  = 100;

    localparam logic [NODE_WIDTH-1:0] NODE_MASK = NODE_WIDTH'((1 << MOD_WIDTH) - 1);

    typedef struct {
        logic [63:0]           hi;
        logic [63:0]           lo;
        logic [NODE_WIDTH-1:0] count;
        logic [NODE_WIDTH-1:0] node;
    } node_txn_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [NODE_WIDTH-1:0]   cfg_wr_data = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [63:0]             digest_high = '0;
    logic [63:0]             digest_low  = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [NODE_WIDTH-1:0]   node_index;

    node_txn_t               pending_nodes[$];
    logic [NODE_WIDTH-1:0]   node_count_q = dni_pkg::NODE_COUNT_RESET & NODE_MASK;
    int                      mismatches    = 0;
    int                      sent_count    = 0;
    int                      checked_count = 0;
    int                      settings_used = 1;
    int                      cycle_count   = 0;
    bit                      stall_on      = 1'b1;
    bit                      gaps_on       = 1'b1;
    int                      stall_hold    = 0;

    digest_to_node_index #(
        .MOD_WIDTH (MOD_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .digest_high (digest_high),
        .digest_low  (digest_low),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .node_index  (node_index)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_nodes.size());
            $display("status: fail");
            $finish;
        end
    end

    // digest mod n, one 32-bit word at a time, most significant word first
    function automatic logic [NODE_WIDTH-1:0] predict_node(input logic [63:0] hi,
                                                           input logic [63:0] lo,
                                                           input logic [NODE_WIDTH-1:0] n);
        logic [31:0] words [4];
        logic [63:0] rem;
        words[0] = hi[63:32];
        words[1] = hi[31:0];
        words[2] = lo[63:32];
        words[3] = lo[31:0];
        rem = '0;
        if (n == '0)
            return '0;
        for (int i = 0; i < 4; i++)
            rem = ((rem << 32) | 64'(words[i])) % 64'(n);
        return rem[NODE_WIDTH-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    always @(posedge clk)
    begin
        int r;
        if (!stall_on)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(1, 12);
            end
            else if (r < 93)
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(1, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(15, 60);
            end
        end
        else
            stall_hold <= stall_hold - 1;
    end

    always @(posedge clk)
    begin
        node_txn_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_nodes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: node_index %0d", node_index);
            end
            else
            begin
                e = pending_nodes.pop_front();
                checked_count++;
                if (node_index !== e.node)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: digest %h_%h node_count %0d expected %0d got %0d",
                                 e.hi, e.lo, e.count, e.node, node_index);
                end
            end
        end
    end

    task automatic send_digest(input logic [63:0] hi, input logic [63:0] lo);
        int        gap;
        node_txn_t e;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        digest_high <= hi;
        digest_low  <= lo;
        e.hi    = hi;
        e.lo    = lo;
        e.count = node_count_q;
        e.node  = predict_node(hi, lo, node_count_q);
        do
            @(posedge clk);
        while (in_stall);
        pending_nodes.push_back(e);
        sent_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [NODE_WIDTH-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        node_count_q = value & NODE_MASK;
        settings_used++;
    endtask

    task automatic send_random_digest();
        int          r;
        logic [63:0] hi;
        logic [63:0] lo;
        r  = $urandom_range(0, 99);
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        if (r >= 70 && r < 80)
            hi = '0;
        else if (r >= 80 && r < 85)
            lo = '0;
        else if (r >= 85 && r < 90)
            hi = '1;
        else if (r >= 90 && r < 93)
            lo = '1;
        else if (r >= 93)
        begin
            hi = '0;
            lo = 64'($urandom_range(0, 200000));
        end
        send_digest(hi, lo);
    endtask

    task automatic send_directed_set(input int count);
        logic [63:0] his [6];
        logic [63:0] los [6];
        his = '{64'h0, '1, 64'h8000_0000_0000_0000, 64'h0,
                64'hFFFF_FFFF_0000_0000, 64'h5555_5555_5555_5555};
        los = '{64'h0, '1, 64'h0, 64'h1,
                64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA};
        for (int i = 0; i < count; i++)
            send_digest(his[i], los[i]);
    endtask

    task automatic test_reset_count();
        send_directed_set(4);
    endtask

    task automatic test_count_extremes();
        write_node_count(16'hFFFF);
        send_directed_set(6);
        write_node_count(16'd1);
        send_directed_set(6);
        write_node_count(16'd0);
        send_directed_set(6);
    endtask

    task automatic test_random_counts();
        logic [NODE_WIDTH-1:0] counts [10];
        counts = '{16'd7, 16'hFFFF, 16'd1, 16'd0, 16'd2, 16'hFFFE,
                   NODE_WIDTH'($urandom_range(1, 65535)),
                   NODE_WIDTH'($urandom_range(3, 255)),
                   NODE_WIDTH'($urandom_range(256, 65535)), 16'h8000};
        foreach (counts[p])
        begin
            write_node_count(counts[p]);
            repeat (PHASE_ITEMS) send_random_digest();
        end
    endtask

    task automatic test_back_to_back();
        write_node_count(NODE_WIDTH'($urandom_range(1, 65535)));
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (BURST_ITEMS) send_random_digest();
        wait_idle();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_count_extremes();
        test_random_counts();
        test_back_to_back();
        wait_idle();

        $display("%0d transactions sent, %0d results checked, %0d node-count settings",
                 sent_count, checked_count, settings_used);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_nodes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
